FILE: hdl/sds_pkg.sv
// Package for the SIMT divergence stack: sizes, instruction codes and stack entry type.
`default_nettype none
package sds_pkg;

	localparam int LANES       = 32;
	localparam int PC_W        = 16;
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_BRANCH = 2'd1,
		MODE_RETURN = 2'd2
	} mode_t;

	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic [LANES-1:0] mask;
	} stk_entry_t;

endpackage
`default_nettype wire

FILE: hdl/sds_ifs.sv
// Valid/ready channel interfaces for issued instructions and warp control results.
`default_nettype none
interface sds_in_if
	import sds_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [1:0]       mode;
	logic             predicated;
	logic [PC_W-1:0]  target;
	logic [LANES-1:0] lane_pred;

	modport source (output valid, output mode, output predicated, output target,
		output lane_pred, input ready);
	modport sink (input valid, input mode, input predicated, input target,
		input lane_pred, output ready);
endinterface

interface sds_out_if
	import sds_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [LANES-1:0] exec_mask;
	logic [PC_W-1:0]  next_pc;
	logic             finished;
	logic             overflow;

	modport source (output valid, output exec_mask, output next_pc, output finished,
		output overflow, input ready);
	modport sink (input valid, input exec_mask, input next_pc, input finished,
		input overflow, output ready);
endinterface
`default_nettype wire

FILE: hdl/simt_divergence_stack.sv
// Warp control unit: program counter, active mask and reconvergence stack.
// A beat waits in the input register, its result in the result register;
// the single-pass update between them reads the top two entries of the stack,
// a shift line. Throughput: one instruction per cycle unless the output stalls.
// Reset: pc 0, active mask all ones, stack empty; stack contents stay unset.
`default_nettype none
module simt_divergence_stack
	import sds_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sds_in_if.sink     issue,
	sds_out_if.source  result
);

	logic             vld_s1;
	mode_t            mode_s1;
	logic             pred_s1;
	logic [PC_W-1:0]  tgt_s1;
	logic [LANES-1:0] lane_s1;

	logic [PC_W-1:0]  pc_q;
	logic [LANES-1:0] act_q;
	logic [CNT_W-1:0] cnt_q;
	stk_entry_t       stk_q [STACK_DEPTH];

	logic             out_vld_q;
	logic [LANES-1:0] exec_q;
	logic [PC_W-1:0]  npc_q;
	logic             fin_q;
	logic             ovf_q;

	logic             advance;
	logic             is_br, is_ret, uni, backward, push_req, push_ok, full, ovf;
	logic             pop1, pop2, fin;
	logic [PC_W-1:0]  pc_adv, pc_b, pc_n;
	logic [LANES-1:0] act_b, act_c, act_n, exec;
	logic [CNT_W-1:0] cnt_b, cnt_c, cnt_n;
	stk_entry_t       push_e, top_b, ret_e;

	assign advance      = vld_s1 && (!out_vld_q || result.ready);
	assign issue.ready  = !vld_s1 || advance;

	always_comb begin
		is_br    = (mode_s1 == MODE_BRANCH);
		is_ret   = (mode_s1 == MODE_RETURN);
		uni      = is_br && !pred_s1;
		pc_adv   = (is_ret && (cnt_q != '0)) ? pc_q : pc_q + PC_W'(1);
		backward = (tgt_s1 < pc_adv);
		push_req = is_br && pred_s1;
		full     = (cnt_q == CNT_W'(STACK_DEPTH));
		push_ok  = push_req && !full;
		ovf      = push_req && full;

		push_e.pc   = backward ? pc_adv : tgt_s1;
		push_e.mask = backward ? ~lane_s1 : lane_s1;

		pc_b  = (is_br && (!pred_s1 || backward)) ? tgt_s1 : pc_adv;
		act_b = push_req ? (backward ? lane_s1 : ~lane_s1) : act_q;
		cnt_b = cnt_q + CNT_W'(push_ok);

		top_b = push_ok ? push_e : stk_q[0];
		pop1  = !uni && (cnt_b != '0) && (pc_b == top_b.pc);
		act_c = pop1 ? top_b.mask : act_b;
		cnt_c = cnt_b - CNT_W'(pop1);
		exec  = uni ? '0 : (act_c & (pred_s1 ? lane_s1 : '1));

		ret_e = pop1 ? stk_q[1] : stk_q[0];
		pop2  = is_ret && (cnt_c != '0);
		fin   = is_ret && (cnt_c == '0);
		pc_n  = pop2 ? ret_e.pc : pc_b;
		act_n = pop2 ? ret_e.mask : act_c;
		cnt_n = cnt_c - CNT_W'(pop2);
	end

	// hold input beat until the result register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (issue.ready) begin
			vld_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.ready && issue.valid) begin
			mode_s1 <= mode_t'(issue.mode);
			pred_s1 <= issue.predicated;
			tgt_s1  <= issue.target;
			lane_s1 <= issue.lane_pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			act_q <= '1;
			cnt_q <= '0;
		end else if (advance) begin
			pc_q  <= pc_n;
			act_q <= act_n;
			cnt_q <= cnt_n;
		end
	end

	// push shifts down, each pop shifts up
	always_ff @(posedge clk) begin
		if (advance) begin
			if (push_ok && !pop1) begin
				stk_q[0] <= push_e;
				for (int k = 1; k < STACK_DEPTH; k++) begin
					stk_q[k] <= stk_q[k-1];
				end
			end else if (pop1 && pop2) begin
				for (int k = 0; k < STACK_DEPTH - 2; k++) begin
					stk_q[k] <= stk_q[k+2];
				end
			end else if ((pop1 && !push_ok) || pop2) begin
				for (int k = 0; k < STACK_DEPTH - 1; k++) begin
					stk_q[k] <= stk_q[k+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			exec_q <= exec;
			npc_q  <= pc_n;
			fin_q  <= fin;
			ovf_q  <= ovf;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.exec_mask = exec_q;
	assign result.next_pc   = npc_q;
	assign result.finished  = fin_q;
	assign result.overflow  = ovf_q;

endmodule
`default_nettype wire

FILE: test/tb_simt_divergence_stack.sv
// Testbench for the SIMT divergence stack: directed table, random instruction streams, predictor.
`timescale 1ns / 100ps
module tb_simt_divergence_stack
	import sds_pkg::*;
	;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int N_RANDOM = 1500;

	typedef struct packed {
		logic [1:0]       mode;
		logic             predicated;
		logic [PC_W-1:0]  target;
		logic [LANES-1:0] lane_pred;
	} instr_t;

	typedef struct packed {
		logic [LANES-1:0] exec_mask;
		logic [PC_W-1:0]  next_pc;
		logic             finished;
		logic             overflow;
	} ctl_res_t;

	typedef struct {
		logic [1:0]       mode;
		logic             predicated;
		logic [PC_W-1:0]  target;
		logic [LANES-1:0] lane_pred;
		int               reps;
		bit               fixed;
		ctl_res_t         want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	sds_in_if  issue_ch ();
	sds_out_if result_ch ();

	simt_divergence_stack dut (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue_ch),
		.result (result_ch)
	);

	logic [PC_W-1:0]  warp_pc;
	logic [LANES-1:0] warp_active;
	logic [PC_W-1:0]  frame_pc [STACK_DEPTH];
	logic [LANES-1:0] frame_mask [STACK_DEPTH];
	int               frame_cnt;

	ctl_res_t expected_q [$];
	int       mismatches;
	int       push_left;
	int       ret_left;

	plan_row_t plan [21] = '{
		'{MODE_PLAIN,  1'b0, 16'h0000, 32'h00000000, 1,  1'b1, '{32'hFFFFFFFF, 16'd1, 1'b0, 1'b0}},
		'{MODE_PLAIN,  1'b1, 16'h0000, 32'hA5A5A5A5, 1,  1'b1, '{32'hA5A5A5A5, 16'd2, 1'b0, 1'b0}},
		'{MODE_RETURN, 1'b0, 16'h0000, 32'h00000000, 1,  1'b1, '{32'hFFFFFFFF, 16'd3, 1'b1, 1'b0}},
		'{MODE_SPARE,  1'b0, 16'hFFFF, 32'hFFFFFFFF, 1,  1'b1, '{32'hFFFFFFFF, 16'd4, 1'b0, 1'b0}},
		'{MODE_BRANCH, 1'b0, 16'hFFFF, 32'h00000000, 1,  1'b1, '{32'h00000000, 16'hFFFF, 1'b0, 1'b0}},
		'{MODE_PLAIN,  1'b1, 16'h0000, 32'hFFFFFFFF, 1,  1'b1, '{32'hFFFFFFFF, 16'd0, 1'b0, 1'b0}},
		'{MODE_BRANCH, 1'b0, 16'h0000, 32'hFFFFFFFF, 1,  1'b1, '{32'h00000000, 16'd0, 1'b0, 1'b0}},
		'{MODE_BRANCH, 1'b1, 16'd10,   32'h0000FFFF, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b0, 16'd9,    32'h00000000, 1,  1'b0, '0},
		'{MODE_PLAIN,  1'b0, 16'h0000, 32'h00000000, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b1, 16'd5,    32'hF0F0F0F0, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b0, 16'd10,   32'h00000000, 1,  1'b0, '0},
		'{MODE_PLAIN,  1'b0, 16'h0000, 32'h00000000, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b1, 16'd0,    32'h00000000, 1,  1'b0, '0},
		'{MODE_RETURN, 1'b1, 16'h0000, 32'hFFFFFFFF, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b1, 16'd100,  32'h00000001, 1,  1'b0, '0},
		'{MODE_RETURN, 1'b0, 16'h0000, 32'h00000000, 1,  1'b0, '0},
		'{MODE_BRANCH, 1'b1, 16'hFFFF, 32'h12345678, 17, 1'b0, '0},
		'{MODE_PLAIN,  1'b1, 16'h0000, 32'h00000000, 1,  1'b0, '0},
		'{MODE_RETURN, 1'b0, 16'h0000, 32'h00000000, 17, 1'b0, '0},
		'{MODE_BRANCH, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 1,  1'b0, '0}
	};

	always #4 clk = ~clk;

	function automatic bit push_frame(logic [PC_W-1:0] pcv, logic [LANES-1:0] maskv);
		if (frame_cnt >= STACK_DEPTH)
			return 1'b0;
		frame_pc[frame_cnt]   = pcv;
		frame_mask[frame_cnt] = maskv;
		frame_cnt++;
		return 1'b1;
	endfunction

	function automatic ctl_res_t warp_step(instr_t ins);
		ctl_res_t         r;
		logic [LANES-1:0] taken;
		bit               is_br;
		bit               is_ret;
		taken  = ins.lane_pred;
		is_br  = (ins.mode == MODE_BRANCH);
		is_ret = (ins.mode == MODE_RETURN);
		r      = '0;
		if (!(is_ret && frame_cnt > 0))
			warp_pc = warp_pc + 1'b1;
		if (is_br && !ins.predicated) begin
			warp_pc     = ins.target;
			r.exec_mask = '0;
		end else begin
			if (is_br) begin
				if (ins.target < warp_pc) begin
					warp_active = taken;
					if (!push_frame(warp_pc, ~taken))
						r.overflow = 1'b1;
					warp_pc = ins.target;
				end else begin
					if (!push_frame(ins.target, taken))
						r.overflow = 1'b1;
					warp_active = ~taken;
				end
			end
			if (frame_cnt > 0 && warp_pc == frame_pc[frame_cnt-1]) begin
				frame_cnt--;
				warp_active = frame_mask[frame_cnt];
			end
			r.exec_mask = ins.predicated ? (warp_active & taken) : warp_active;
		end
		if (is_ret) begin
			if (frame_cnt == 0) begin
				r.finished = 1'b1;
			end else begin
				frame_cnt--;
				warp_pc     = frame_pc[frame_cnt];
				warp_active = frame_mask[frame_cnt];
			end
		end
		r.next_pc = warp_pc;
		return r;
	endfunction

	function automatic instr_t random_instr();
		instr_t b;
		int     k;
		b = '0;
		if (push_left > 0) begin
			push_left--;
			b.mode       = MODE_BRANCH;
			b.predicated = 1'b1;
			b.target     = warp_pc + 16'd300 + 16'($urandom_range(0, 255));
			b.lane_pred  = $urandom;
			return b;
		end
		if (ret_left > 0) begin
			ret_left--;
			b.mode      = MODE_RETURN;
			b.lane_pred = $urandom;
			return b;
		end
		k = $urandom_range(0, 99);
		if (k == 0) begin
			push_left = $urandom_range(16, 20);
			ret_left  = $urandom_range(4, 20);
		end
		if (k < 50)
			b.mode = MODE_PLAIN;
		else if (k < 80)
			b.mode = MODE_BRANCH;
		else if (k < 95)
			b.mode = MODE_RETURN;
		else
			b.mode = MODE_SPARE;
		if (b.mode == MODE_BRANCH)
			b.predicated = ($urandom_range(0, 9) < 7);
		else
			b.predicated = ($urandom_range(0, 9) < 3);
		case ($urandom_range(0, 9))
			0: b.target = 16'($urandom);
			1: b.target = '0;
			2: b.target = '1;
			3, 4, 5, 6: b.target = warp_pc + 16'($urandom_range(1, 8));
			default: b.target = warp_pc - 16'($urandom_range(0, 8));
		endcase
		case ($urandom_range(0, 7))
			0: b.lane_pred = '0;
			1: b.lane_pred = '1;
			2: b.lane_pred = warp_active & $urandom;
			default: b.lane_pred = $urandom;
		endcase
		return b;
	endfunction

	int src_calm;

	task automatic send_beat(instr_t b, bit fixed, ctl_res_t want);
		int       gap;
		ctl_res_t r;
		if (src_calm > 0) begin
			src_calm--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 39) == 0)
				src_calm = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			issue_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		issue_ch.valid      <= 1'b1;
		issue_ch.mode       <= b.mode;
		issue_ch.predicated <= b.predicated;
		issue_ch.target     <= b.target;
		issue_ch.lane_pred  <= b.lane_pred;
		do @(posedge clk); while (!issue_ch.ready);
		r = warp_step(b);
		expected_q.insert(expected_q.size(), fixed ? want : r);
	endtask

	task automatic drain_wait();
		issue_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result(ctl_res_t got);
		ctl_res_t want;
		if (expected_q.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result beat: %h", got);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (got.exec_mask !== want.exec_mask || got.next_pc !== want.next_pc ||
				got.finished !== want.finished || got.overflow !== want.overflow) begin
			if (mismatches < 10)
				$display("mismatch: mask %h/%h pc %h/%h fin %b/%b ovf %b/%b (exp/got)",
					want.exec_mask, got.exec_mask, want.next_pc, got.next_pc,
					want.finished, got.finished, want.overflow, got.overflow);
			mismatches++;
		end
	endtask

	initial begin
		int stall;
		int calm;
		calm            = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm > 0) begin
				calm--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 10);
				if ($urandom_range(0, 39) == 0)
					calm = $urandom_range(20, 60);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			check_result('{result_ch.exec_mask, result_ch.next_pc, result_ch.finished,
				result_ch.overflow});
		end
	end

	initial begin
		#5_000_000;
		$display("[simt_divergence_stack] ERROR");
		$finish;
	end

	initial begin
		instr_t b;
		int     waited;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		issue_ch.valid      = 1'b0;
		issue_ch.mode       = MODE_PLAIN;
		issue_ch.predicated = 1'b0;
		issue_ch.target     = '0;
		issue_ch.lane_pred  = '0;
		warp_pc             = '0;
		warp_active         = '1;
		frame_cnt           = 0;
		mismatches          = 0;
		push_left           = 0;
		ret_left            = 0;
		src_calm            = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			b = '{plan[i].mode, plan[i].predicated, plan[i].target, plan[i].lane_pred};
			repeat (plan[i].reps)
				send_beat(b, plan[i].fixed, plan[i].want);
		end

		drain_wait();

		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 199) == 0)
				drain_wait();
			send_beat(random_instr(), 1'b0, '0);
		end
		issue_ch.valid <= 1'b0;

		waited = 0;
		while (expected_q.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_q.size() != 0) begin
			$display("missing result beats: %0d", expected_q.size());
			mismatches++;
		end
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("[simt_divergence_stack] OK");
		else
			$display("[simt_divergence_stack] ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/sds_pkg.sv
hdl/sds_ifs.sv
hdl/simt_divergence_stack.sv
test/tb_simt_divergence_stack.sv
